>>> hdl/jbt_pkg.sv
// Shared types, codes and helper functions for the JSON byte tokenizer.
package jbt_pkg;

  localparam int MaxFractionDigits = 18;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [29:0] ExpLimit = 30'd999999999;

  // Token kinds
  localparam logic [3:0] TK_LBRACE  = 4'd0;
  localparam logic [3:0] TK_RBRACE  = 4'd1;
  localparam logic [3:0] TK_LBRACK  = 4'd2;
  localparam logic [3:0] TK_RBRACK  = 4'd3;
  localparam logic [3:0] TK_COMMA   = 4'd4;
  localparam logic [3:0] TK_COLON   = 4'd5;
  localparam logic [3:0] TK_NULL    = 4'd6;
  localparam logic [3:0] TK_STRBYTE = 4'd9;
  localparam logic [3:0] TK_STREND  = 4'd10;
  localparam logic [3:0] TK_NUMBER  = 4'd11;
  localparam logic [3:0] TK_END     = 4'd12;
  localparam logic [3:0] TK_ERROR   = 4'd13;

  // Scanner modes
  localparam logic [3:0] M_TOP    = 4'd0;
  localparam logic [3:0] M_LIT    = 4'd1;
  localparam logic [3:0] M_STR    = 4'd2;
  localparam logic [3:0] M_ESC    = 4'd3;
  localparam logic [3:0] M_NSIGN  = 4'd4;
  localparam logic [3:0] M_NZERO  = 4'd5;
  localparam logic [3:0] M_NINT   = 4'd6;
  localparam logic [3:0] M_FSTART = 4'd7;
  localparam logic [3:0] M_FRAC   = 4'd8;
  localparam logic [3:0] M_ESTART = 4'd9;
  localparam logic [3:0] M_ESIGN  = 4'd10;
  localparam logic [3:0] M_EXP    = 4'd11;
  localparam logic [3:0] M_STOP   = 4'd12;

  // Literal selects
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         ch;
    logic signed [63:0] ival;
    logic [59:0]        fval;
    logic [4:0]         fdig;
    logic signed [30:0] eval;
    logic               ovf;
    logic [31:0]        line;
    logic [31:0]        col;
    logic               last;
  } res_t;

  function automatic res_t mk_tok(logic [3:0] kind, logic [7:0] ch,
                                  logic [31:0] line, logic [31:0] col);
    res_t r;
    r = '0;
    r.kind = kind;
    r.ch = ch;
    r.line = line;
    r.col = col;
    return r;
  endfunction

  // Character of a literal at a position; an unused select reads as null.
  function automatic logic [7:0] lit_char(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (sel)
      LIT_TRUE: begin
        case (pos)
          3'd0: c = "t";
          3'd1: c = "r";
          3'd2: c = "u";
          3'd3: c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (pos)
          3'd0: c = "f";
          3'd1: c = "a";
          3'd2: c = "l";
          3'd3: c = "s";
          3'd4: c = "e";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: c = "n";
          3'd1: c = "u";
          3'd2: c = "l";
          3'd3: c = "l";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] sel);
    logic [2:0] l;
    case (sel)
      LIT_FALSE: l = 3'd5;
      default:   l = 3'd4;
    endcase
    return l;
  endfunction

  // Escape decode: bit 8 set means the escape is not supported.
  function automatic logic [8:0] esc_decode(logic [7:0] b);
    logic [8:0] v;
    case (b)
      8'h22:   v = 9'h022;
      8'h5C:   v = 9'h05C;
      8'h2F:   v = 9'h02F;
      "b":     v = 9'h008;
      "f":     v = 9'h00C;
      "n":     v = 9'h00A;
      "r":     v = 9'h00D;
      "t":     v = 9'h009;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

  // Integer digit with saturation: {saturated, new value}.
  function automatic logic [64:0] int_step(logic [63:0] acc, logic [3:0] d, logic neg);
    logic [67:0] t;
    logic [67:0] lim;
    logic [64:0] r;
    t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 68'(d);
    lim = neg ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
    if (t > lim) r = {1'b1, lim[63:0]};
    else r = {1'b0, t[63:0]};
    return r;
  endfunction

  // Exponent digit with saturation: {saturated, new value}.
  function automatic logic [30:0] exp_step(logic [29:0] acc, logic [3:0] d);
    logic [33:0] t;
    logic [30:0] r;
    t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 34'(d);
    if (t > {4'b0, ExpLimit}) r = {1'b1, ExpLimit};
    else r = {1'b0, t[29:0]};
    return r;
  endfunction

endpackage

>>> hdl/jbt_queue.sv
// Four-entry result queue that takes up to two tokens per cycle.
module jbt_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     push_n,
  input  jbt_pkg::res_t                  push_d0,
  input  jbt_pkg::res_t                  push_d1,
  input  logic                           pop,
  output logic [jbt_pkg::QueueCntW-1:0]  level,
  output logic                           head_valid,
  output jbt_pkg::res_t                  head
);
  import jbt_pkg::*;

  res_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QueueCntW-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign wp_nxt = wp_r + QueuePtrW'(push_n);
  assign rp_nxt = rp_r + QueuePtrW'(do_pop);
  assign cnt_nxt = cnt_r + QueueCntW'(push_n) - QueueCntW'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push_d0;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + QueuePtrW'(1)] <= push_d1;
    end
  end

  assign level = cnt_r;
  assign head_valid = cnt_r != '0;
  assign head = mem[rp_r];

endmodule

>>> hdl/json_byte_tokenizer.sv
// Top level of the JSON byte tokenizer: scanner state and result queue.
//
// Input channel: in_data_byte / in_end_of_text, moved by in_valid and in_stall.
// One byte of JSON text is consumed per transfer; a zero byte or a set
// in_end_of_text ends the text and flushes any complete pending number.
// Result channel: one token per transfer on out_*, with out_last_result set
// on the final token caused by a given input byte (zero, one or two tokens).
// Latency: a token caused by a byte is offered on the result channel in the
// cycle after the byte's transfer when the queue is empty.
// Throughput: one byte per cycle. The scanner decides each byte with one
// level of logic (mode decode plus one multiply-by-ten add and compare), so
// the figure is set by the result queue: in_stall rises while three or more
// tokens wait, so a receiver that stalls, or a run of bytes giving two
// tokens each (a number closed by punctuation), backs up the input.
// Reset: rst_n, synchronous, active low, returns the scanner to between
// tokens at line 0, column 0 and empties the queue.
// After an end or error token the scanner stops and later bytes are taken
// but give no tokens until reset.
module json_byte_tokenizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_token_kind,
  output logic [7:0]         out_char_value,
  output logic signed [63:0] out_integer_value,
  output logic [59:0]        out_fraction_value,
  output logic [4:0]         out_fraction_digits,
  output logic signed [30:0] out_exponent_value,
  output logic               out_overflow_flag,
  output logic [31:0]        out_token_line,
  output logic [31:0]        out_token_column,
  output logic               out_last_result
);
  import jbt_pkg::*;

  // Scanner state
  logic [3:0]  mode_r, mode_nxt;
  logic [1:0]  lsel_r, lsel_nxt;
  logic [2:0]  lpos_r, lpos_nxt;
  logic        nneg_r, nneg_nxt;
  logic [63:0] iacc_r, iacc_nxt;
  logic [59:0] facc_r, facc_nxt;
  logic [4:0]  fcnt_r, fcnt_nxt;
  logic [29:0] eacc_r, eacc_nxt;
  logic        eneg_r, eneg_nxt;
  logic        sat_r, sat_nxt;
  logic [31:0] line_r, line_nxt, col_r, col_nxt;
  logic [31:0] sline_r, sline_nxt, scol_r, scol_nxt;

  logic                 accept;
  logic [1:0]           push_n;
  res_t                 push_d0, push_d1, head;
  logic [QueueCntW-1:0] level;
  logic                 is_end;

  // Hold off input while the queue may not fit two more tokens.
  assign in_stall = level > QueueCntW'(QueueDepth - 2);
  assign accept = in_valid && !in_stall;
  assign is_end = in_end_of_text || (in_data_byte == 8'h00);

  always_comb begin
    logic [7:0]  b;
    logic        digit;
    logic [3:0]  d;
    logic        num_emit, tok_emit, do_top;
    res_t        tok, num;
    logic [64:0] istep;
    logic [30:0] estep;
    logic [63:0] fmul;
    logic [2:0]  pos;
    logic [8:0]  esc;
    logic [30:0] ex;

    b = in_data_byte;
    digit = (b >= "0") && (b <= "9");
    d = digit ? 4'(b - 8'h30) : 4'd0;
    num_emit = 1'b0;
    tok_emit = 1'b0;
    do_top = 1'b0;
    tok = '0;
    istep = int_step(iacc_r, d, nneg_r);
    estep = exp_step(eacc_r, d);
    fmul = ({4'b0, facc_r} << 3) + ({4'b0, facc_r} << 1) + 64'(d);
    pos = (lpos_r < lit_len(lsel_r)) ? lpos_r : 3'd0;
    esc = esc_decode(b);

    // Number token from the pending state
    num = mk_tok(TK_NUMBER, 8'h00, sline_r, scol_r);
    num.ival = nneg_r ? -$signed(iacc_r) : $signed(iacc_r);
    num.fval = facc_r;
    num.fdig = fcnt_r;
    ex = {1'b0, eacc_r};
    num.eval = eneg_r ? $signed(~ex + 31'd1) : $signed(ex);
    num.ovf = sat_r;

    mode_nxt = mode_r;
    lsel_nxt = lsel_r;
    lpos_nxt = lpos_r;
    nneg_nxt = nneg_r;
    iacc_nxt = iacc_r;
    facc_nxt = facc_r;
    fcnt_nxt = fcnt_r;
    eacc_nxt = eacc_r;
    eneg_nxt = eneg_r;
    sat_nxt = sat_r;
    line_nxt = line_r;
    col_nxt = col_r;
    sline_nxt = sline_r;
    scol_nxt = scol_r;

    if (accept && mode_r != M_STOP) begin
      if (is_end) begin
        case (mode_r)
          M_TOP: begin
            tok_emit = 1'b1;
            tok = mk_tok(TK_END, 8'h00, line_r, col_r);
          end
          M_NZERO, M_NINT, M_FRAC, M_EXP: begin
            num_emit = 1'b1;
            tok_emit = 1'b1;
            tok = mk_tok(TK_END, 8'h00, line_r, col_r);
          end
          default: begin
            tok_emit = 1'b1;
            tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
          end
        endcase
        mode_nxt = M_STOP;
      end else begin
        case (mode_r)
          M_TOP: do_top = 1'b1;
          M_LIT: begin
            if (pos != 3'd0 && b == lit_char(lsel_r, pos)) begin
              lpos_nxt = pos + 3'd1;
              if (pos + 3'd1 == lit_len(lsel_r)) begin
                tok_emit = 1'b1;
                tok = mk_tok(TK_NULL + 4'(lsel_r), 8'h00, sline_r, scol_r);
                mode_nxt = M_TOP;
                lpos_nxt = 3'd0;
              end
            end else begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
              mode_nxt = M_STOP;
            end
          end
          M_STR: begin
            if (b == 8'h22) begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_STREND, 8'h00, sline_r, scol_r);
              mode_nxt = M_TOP;
            end else if (b == 8'h5C) begin
              mode_nxt = M_ESC;
            end else if (b < 8'h20) begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
              mode_nxt = M_STOP;
            end else begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_STRBYTE, b, sline_r, scol_r);
            end
          end
          M_ESC: begin
            tok_emit = 1'b1;
            if (esc[8]) begin
              tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
              mode_nxt = M_STOP;
            end else begin
              tok = mk_tok(TK_STRBYTE, esc[7:0], sline_r, scol_r);
              mode_nxt = M_STR;
            end
          end
          M_NSIGN: begin
            if (b == "0") begin
              mode_nxt = M_NZERO;
            end else if (digit) begin
              iacc_nxt = istep[63:0];
              sat_nxt = sat_r | istep[64];
              mode_nxt = M_NINT;
            end else begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
              mode_nxt = M_STOP;
            end
          end
          M_NZERO, M_NINT: begin
            if (digit && mode_r == M_NINT) begin
              iacc_nxt = istep[63:0];
              sat_nxt = sat_r | istep[64];
            end else if (b == ".") begin
              mode_nxt = M_FSTART;
            end else if (b == "e" || b == "E") begin
              mode_nxt = M_ESTART;
            end else begin
              num_emit = 1'b1;
              do_top = 1'b1;
            end
          end
          M_FSTART, M_FRAC: begin
            if (digit) begin
              if (fcnt_r < 5'(MaxFractionDigits)) begin
                facc_nxt = fmul[59:0];
                fcnt_nxt = fcnt_r + 5'd1;
              end else begin
                sat_nxt = 1'b1;
              end
              mode_nxt = M_FRAC;
            end else if (mode_r == M_FSTART) begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
              mode_nxt = M_STOP;
            end else if (b == "e" || b == "E") begin
              mode_nxt = M_ESTART;
            end else begin
              num_emit = 1'b1;
              do_top = 1'b1;
            end
          end
          M_ESTART, M_ESIGN: begin
            if (digit) begin
              eacc_nxt = estep[29:0];
              sat_nxt = sat_r | estep[30];
              mode_nxt = M_EXP;
            end else if (mode_r == M_ESTART && b == "-") begin
              eneg_nxt = 1'b1;
              mode_nxt = M_ESIGN;
            end else if (mode_r == M_ESTART && b == "+") begin
              mode_nxt = M_ESIGN;
            end else begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_ERROR, 8'h00, sline_r, scol_r);
              mode_nxt = M_STOP;
            end
          end
          M_EXP: begin
            if (digit) begin
              eacc_nxt = estep[29:0];
              sat_nxt = sat_r | estep[30];
            end else begin
              num_emit = 1'b1;
              do_top = 1'b1;
            end
          end
          default: mode_nxt = M_STOP;
        endcase

        // Between tokens: mark the start and dispatch on the byte.
        if (do_top) begin
          mode_nxt = M_TOP;
          sline_nxt = line_r;
          scol_nxt = col_r;
          case (b)
            " ", 8'h09, 8'h0D, 8'h0A: ;
            "{": begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_LBRACE, 8'h00, line_r, col_r);
            end
            "}": begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_RBRACE, 8'h00, line_r, col_r);
            end
            "[": begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_LBRACK, 8'h00, line_r, col_r);
            end
            "]": begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_RBRACK, 8'h00, line_r, col_r);
            end
            ",": begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_COMMA, 8'h00, line_r, col_r);
            end
            ":": begin
              tok_emit = 1'b1;
              tok = mk_tok(TK_COLON, 8'h00, line_r, col_r);
            end
            "n": begin
              lsel_nxt = LIT_NULL;
              lpos_nxt = 3'd1;
              mode_nxt = M_LIT;
            end
            "t": begin
              lsel_nxt = LIT_TRUE;
              lpos_nxt = 3'd1;
              mode_nxt = M_LIT;
            end
            "f": begin
              lsel_nxt = LIT_FALSE;
              lpos_nxt = 3'd1;
              mode_nxt = M_LIT;
            end
            8'h22: mode_nxt = M_STR;
            default: begin
              if (b == "-" || digit) begin
                nneg_nxt = (b == "-");
                iacc_nxt = 64'(d);
                facc_nxt = '0;
                fcnt_nxt = '0;
                eacc_nxt = '0;
                eneg_nxt = 1'b0;
                sat_nxt = 1'b0;
                if (b == "-") mode_nxt = M_NSIGN;
                else if (b == "0") mode_nxt = M_NZERO;
                else mode_nxt = M_NINT;
              end else begin
                tok_emit = 1'b1;
                tok = mk_tok(TK_ERROR, 8'h00, line_r, col_r);
                mode_nxt = M_STOP;
              end
            end
          endcase
        end

        // Advance the text position.
        if (b == 8'h0A) begin
          line_nxt = line_r + 32'd1;
          col_nxt = '0;
        end else begin
          col_nxt = col_r + 32'd1;
        end
      end
    end

    // Pack the tokens, number first, and flag the last one.
    push_n = 2'(num_emit) + 2'(tok_emit);
    tok.last = 1'b1;
    num.last = !tok_emit;
    push_d0 = num_emit ? num : tok;
    push_d1 = tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TOP;
      lsel_r <= '0;
      lpos_r <= '0;
      nneg_r <= 1'b0;
      iacc_r <= '0;
      facc_r <= '0;
      fcnt_r <= '0;
      eacc_r <= '0;
      eneg_r <= 1'b0;
      sat_r <= 1'b0;
      line_r <= '0;
      col_r <= '0;
      sline_r <= '0;
      scol_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      lsel_r <= lsel_nxt;
      lpos_r <= lpos_nxt;
      nneg_r <= nneg_nxt;
      iacc_r <= iacc_nxt;
      facc_r <= facc_nxt;
      fcnt_r <= fcnt_nxt;
      eacc_r <= eacc_nxt;
      eneg_r <= eneg_nxt;
      sat_r <= sat_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      sline_r <= sline_nxt;
      scol_r <= scol_nxt;
    end
  end

  jbt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push_d0    (push_d0),
    .push_d1    (push_d1),
    .pop        (!out_stall),
    .level      (level),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_token_kind = head.kind;
  assign out_char_value = head.ch;
  assign out_integer_value = head.ival;
  assign out_fraction_value = head.fval;
  assign out_fraction_digits = head.fdig;
  assign out_exponent_value = head.eval;
  assign out_overflow_flag = head.ovf;
  assign out_token_line = head.line;
  assign out_token_column = head.col;
  assign out_last_result = head.last;

  // An end of text always stops the scanner.
  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_end |=> mode_r == M_STOP)
    else $error("scanner not stopped after end of text");

  // A stopped scanner gives no tokens.
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_STOP |-> push_n == 2'd0)
    else $error("token pushed while stopped");

  // The queue never overfills.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_n != 2'd0 |-> level + QueueCntW'(push_n) <= QueueCntW'(QueueDepth))
    else $error("result queue overflow");

  // Fraction count and exponent stay within their limits.
  a_num_limits: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 5'(MaxFractionDigits) && eacc_r <= ExpLimit)
    else $error("number accumulator beyond limit");

endmodule
